/* design/lcd_decimal_number_writer_defines.svh */
// ----------------------------------------------------------------------------
// LCD decimal number writer assertion macros
// Shared assertion forms for the checker of the number writer.
// ----------------------------------------------------------------------------
`ifndef LCD_DECIMAL_NUMBER_WRITER_DEFINES_SVH
`define LCD_DECIMAL_NUMBER_WRITER_DEFINES_SVH

// clocked assertion, disabled while reset is asserted
`define LDNW_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// clocked assertion, also checked during reset
`define LDNW_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/ldnw_pkg.sv */
// ----------------------------------------------------------------------------
// LCD decimal number writer package
// Widths, byte constants and word types shared by the number writer.
// ----------------------------------------------------------------------------
`default_nettype none

package ldnw_pkg;

  localparam int NumberBits = 16;
  localparam int NumDigits  = (NumberBits * 30103) / 100000 + 1;
  localparam int BcdBits    = 4 * NumDigits;
  localparam int BitCntW    = $clog2(NumberBits + 1);
  localparam int DigCntW    = $clog2(NumDigits + 1);

  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] Row1Base  = 8'h80;
  localparam logic [7:0] Row2Base  = 8'hC0;
  localparam logic [7:0] NoBase    = 8'h00;
  localparam logic [7:0] CmdClear  = 8'h01;
  localparam logic [7:0] CmdHome   = 8'h02;

  localparam logic [1:0] RowOne    = 2'd1;
  localparam logic [1:0] RowTwo    = 2'd2;
  localparam logic [1:0] WaitShort = 2'd1;
  localparam logic [1:0] WaitLong  = 2'd2;

  typedef struct packed {
    logic [NumberBits-1:0] number;
    logic                  at_position;
    logic [1:0]            row;
    logic [5:0]            col;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       reg_select;
    logic [1:0] wait_units;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic shift_digit;
  } conv_ctl_t;

  typedef struct packed {
    logic       done;
    logic [3:0] top_digit;
  } conv_stat_t;

endpackage

`default_nettype wire

/* design/ldnw_conv.sv */
// ----------------------------------------------------------------------------
// Bit-serial binary to BCD converter
// Shifts the number in one bit per cycle with per-digit add-3 correction,
// then hands out the digits most significant first, one per shift.
// ----------------------------------------------------------------------------
`default_nettype none

module ldnw_conv
  import ldnw_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [NumberBits-1:0] number_i,
  input  wire conv_ctl_t             ctl_i,
  output      conv_stat_t            stat_o
);

  logic [NumberBits-1:0] bin_q, bin_d;
  logic [BcdBits-1:0]    bcd_q, bcd_d;
  logic [BcdBits-1:0]    adj;
  logic [BitCntW-1:0]    cnt_q, cnt_d;
  logic                  running_q, running_d;
  logic                  done_q, done_d;

  always_comb begin
    logic [3:0] dig;
    dig = '0;
    for (int d = 0; d < NumDigits; d++) begin
      dig = bcd_q[4*d +: 4];
      if (dig >= 4'd5) begin
        dig = dig + 4'd3;
      end
      adj[4*d +: 4] = dig;
    end
  end

  always_comb begin
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    cnt_d     = cnt_q;
    running_d = running_q;
    done_d    = 1'b0;
    if (ctl_i.load) begin
      bin_d     = number_i;
      bcd_d     = '0;
      cnt_d     = BitCntW'(NumberBits);
      running_d = 1'b1;
    end else if (running_q) begin
      bcd_d = {adj[BcdBits-2:0], bin_q[NumberBits-1]};
      bin_d = {bin_q[NumberBits-2:0], 1'b0};
      cnt_d = cnt_q - BitCntW'(1);
      if (cnt_q == BitCntW'(1)) begin
        running_d = 1'b0;
        done_d    = 1'b1;
      end
    end else if (ctl_i.shift_digit) begin
      bcd_d = {bcd_q[BcdBits-5:0], 4'b0000};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      running_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      running_q <= running_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign stat_o.done      = done_q;
  assign stat_o.top_digit = bcd_q[BcdBits-1 -: 4];

endmodule

`default_nettype wire

/* design/lcd_decimal_number_writer.sv */
// ----------------------------------------------------------------------------
// LCD decimal number writer
// Turns an unsigned number into character-LCD bus writes: an optional
// cursor-move command, then the decimal digits as ASCII data bytes.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Busy then stays high
// through bit-serial BCD conversion of the number, then through a scan that
// drops leading zeros and the emission of the digits. If the cursor command
// is asked for, it is registered from the pending flag and shown while the
// conversion runs. Each write is shown for one cycle with strobe_o high, and
// the receiver cannot hold it off. The final write of an item carries last.
// It is shown in the cycle in which busy falls, so the next item can be taken
// at the same edge that takes that write.
`default_nettype none

module lcd_decimal_number_writer
  import ldnw_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output      logic      busy,
  input  wire in_word_t  item_i,
  output      logic      strobe_o,
  output      out_word_t result_o
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StConv = 4'b0010,
    StScan = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic               pend_q, pend_d;
  logic [7:0]         cmd_q, cmd_d;
  logic [DigCntW-1:0] dig_left_q, dig_left_d;
  logic               strobe_q, strobe_d;
  out_word_t          res_q, res_d;
  logic [7:0]         base;
  conv_ctl_t          conv_ctl;
  conv_stat_t         conv_stat;

  ldnw_conv u_conv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .number_i (item_i.number),
    .ctl_i    (conv_ctl),
    .stat_o   (conv_stat)
  );

  always_comb begin
    unique case (item_i.row)
      RowOne:  base = Row1Base;
      RowTwo:  base = Row2Base;
      default: base = NoBase;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    pend_d     = pend_q;
    cmd_d      = cmd_q;
    dig_left_d = dig_left_q;
    strobe_d   = 1'b0;
    res_d      = res_q;
    conv_ctl   = '0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          conv_ctl.load = 1'b1;
          pend_d        = item_i.at_position;
          cmd_d         = base + {2'b00, item_i.col} - 8'd1;
          state_d       = StConv;
        end
      end
      StConv: begin
        if (pend_q) begin
          strobe_d         = 1'b1;
          res_d.out_byte   = cmd_q;
          res_d.reg_select = 1'b0;
          res_d.wait_units = (cmd_q == CmdClear || cmd_q == CmdHome) ? WaitLong : WaitShort;
          res_d.last       = 1'b0;
          pend_d           = 1'b0;
        end
        if (conv_stat.done) begin
          dig_left_d = DigCntW'(NumDigits);
          state_d    = StScan;
        end
      end
      StScan: begin
        // drop leading zeros, keep at least one digit
        if (conv_stat.top_digit == 4'd0 && dig_left_q != DigCntW'(1)) begin
          conv_ctl.shift_digit = 1'b1;
          dig_left_d           = dig_left_q - DigCntW'(1);
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        strobe_d             = 1'b1;
        res_d.out_byte       = AsciiZero | {4'b0000, conv_stat.top_digit};
        res_d.reg_select     = 1'b1;
        res_d.wait_units     = WaitShort;
        res_d.last           = (dig_left_q == DigCntW'(1));
        conv_ctl.shift_digit = 1'b1;
        dig_left_d           = dig_left_q - DigCntW'(1);
        if (dig_left_q == DigCntW'(1)) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      pend_q     <= 1'b0;
      dig_left_q <= '0;
      strobe_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      pend_q     <= pend_d;
      dig_left_q <= dig_left_d;
      strobe_q   <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    res_q <= res_d;
  end

  assign busy     = (state_q != StIdle);
  assign strobe_o = strobe_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

/* design/ldnw_checker.sv */
// ----------------------------------------------------------------------------
// LCD decimal number writer checker
// Port-level checks on write ordering and busy timing, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lcd_decimal_number_writer_defines.svh"

module ldnw_checker
  import ldnw_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      strobe_o,
  input wire out_word_t result_o
);

  `LDNW_ASSERT(a_mid_write_busy, clk_i, rst_ni, strobe_o && !result_o.last |-> busy, "write before last while idle")
  `LDNW_ASSERT(a_last_gap, clk_i, rst_ni, strobe_o && result_o.last |=> !strobe_o, "write right after last")
  `LDNW_ASSERT(a_accept_busy, clk_i, rst_ni, start && !busy |=> busy && !strobe_o, "accept did not raise busy")
  `LDNW_ASSERT(a_cmd_not_last, clk_i, rst_ni, strobe_o && (!result_o.reg_select || result_o.wait_units == WaitLong) |-> !result_o.last && !result_o.reg_select, "bad command write")

endmodule

bind lcd_decimal_number_writer ldnw_checker u_ldnw_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .strobe_o (strobe_o),
  .result_o (result_o)
);

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LCD decimal number writer testbench
// Feeds numbers with and without cursor positioning, first a directed set
// of edge values and then random ones, and checks every LCD bus write
// against a local predictor of the command and ASCII digit bytes.
// ----------------------------------------------------------------------------

module tb;
  import ldnw_pkg::*;

  localparam int NumRandom  = 160;
  localparam int IdlePct    = 26;
  localparam int StallLimit = 2000;
  localparam int DrainWait  = 40;
  localparam int MaxPrints  = 20;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  item_i = '0;
  logic      strobe_o;
  out_word_t result_o;

  in_word_t  lcd_item_q[$];
  out_word_t bus_write_q[$];

  logic item_taken = 1'b0;
  int   err_cnt = 0;
  int   items_sent = 0;
  int   items_taken = 0;
  int   moves_taken = 0;
  int   writes_checked = 0;
  int   stall_cnt = 0;

  lcd_decimal_number_writer dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .strobe_o (strobe_o),
    .result_o (result_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    if (err_cnt < MaxPrints) $display("mismatch at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic void add_item(input int unsigned num, input bit at, input int unsigned r,
                                   input int unsigned c);
    in_word_t w;
    w.number      = NumberBits'(num);
    w.at_position = at;
    w.row         = 2'(r);
    w.col         = 6'(c);
    lcd_item_q.push_back(w);
  endfunction

  function automatic in_word_t random_item();
    in_word_t    w;
    int unsigned p;
    w.at_position = 1'($urandom_range(1));
    w.row         = 2'($urandom_range(3));
    w.col         = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(40, 1));
    case ($urandom_range(3))
      0: w.number = NumberBits'($urandom_range(9));
      1: w.number = NumberBits'($urandom);
      2: begin
        p = 10 ** $urandom_range(5, 1);
        w.number = NumberBits'($urandom_range(65535) % p);
      end
      default: begin
        p = 10 ** $urandom_range(4);
        w.number = NumberBits'(p - $urandom_range(1));
      end
    endcase
    return w;
  endfunction

  function automatic void predict_bus_writes(input in_word_t w);
    logic [7:0]            base;
    logic [7:0]            cmd;
    logic [NumberBits-1:0] rest;
    logic [3:0]            digs[$];
    out_word_t             o;
    if (w.at_position) begin
      base = (w.row == RowOne) ? Row1Base : (w.row == RowTwo) ? Row2Base : NoBase;
      cmd  = base + {2'b00, w.col} - 8'd1;
      o.out_byte   = cmd;
      o.reg_select = 1'b0;
      o.wait_units = (cmd == CmdClear || cmd == CmdHome) ? WaitLong : WaitShort;
      o.last       = 1'b0;
      bus_write_q.push_back(o);
    end
    rest = w.number;
    do begin
      digs.push_front(4'(rest % 10));
      rest = rest / 10;
    end while (rest != 0);
    foreach (digs[i]) begin
      o.out_byte   = AsciiZero + {4'h0, digs[i]};
      o.reg_select = 1'b1;
      o.wait_units = WaitShort;
      o.last       = (i == digs.size() - 1);
      bus_write_q.push_back(o);
    end
  endfunction

  task automatic check_write(input out_word_t got);
    out_word_t want;
    if (bus_write_q.size() == 0) begin
      report_mismatch($sformatf("unexpected write byte=%02h", got.out_byte));
    end else begin
      want = bus_write_q.pop_front();
      writes_checked++;
      if (got.out_byte !== want.out_byte)
        report_mismatch($sformatf("out_byte got %02h want %02h", got.out_byte, want.out_byte));
      if (got.reg_select !== want.reg_select)
        report_mismatch($sformatf("reg_select got %b want %b", got.reg_select,
                                  want.reg_select));
      if (got.wait_units !== want.wait_units)
        report_mismatch($sformatf("wait_units got %0d want %0d", got.wait_units,
                                  want.wait_units));
      if (got.last !== want.last)
        report_mismatch($sformatf("last got %b want %b", got.last, want.last));
    end
  endtask

  // driver: hold the current word until taken, then idle or advance
  always @(negedge clk_i) begin
    logic     go;
    logic     calm;
    in_word_t nxt;
    calm = (items_sent >= 70 && items_sent < 120);
    go   = start;
    if (!rst_ni) begin
      go = 1'b0;
    end else if (!start || item_taken) begin
      go = 1'b0;
      if (lcd_item_q.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
        nxt = lcd_item_q.pop_front();
        item_i <= nxt;
        items_sent++;
        go = 1'b1;
      end
    end
    start <= go;
  end

  // monitor: predict on accept, check on strobe
  always @(posedge clk_i) begin
    item_taken <= rst_ni && start && !busy;
    if (rst_ni) begin
      if (start && !busy) begin
        predict_bus_writes(item_i);
        items_taken++;
        if (item_i.at_position) moves_taken++;
      end
      if (strobe_o) check_write(result_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || strobe_o) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    add_item(0, 1'b0, 0, 0);
    add_item(65535, 1'b1, 1, 40);
    add_item(1, 1'b1, 2, 1);
    add_item(9, 1'b1, 0, 2);
    add_item(10, 1'b1, 0, 3);
    add_item(99, 1'b1, 3, 1);
    add_item(100, 1'b1, 0, 0);
    add_item(999, 1'b1, 1, 0);
    add_item(1000, 1'b1, 2, 63);
    add_item(9999, 1'b1, 3, 63);
    add_item(10000, 1'b0, 3, 63);
    add_item(54321, 1'b0, 1, 21);
    add_item(0, 1'b1, 1, 1);
    add_item(0, 1'b1, 3, 3);
    add_item(32768, 1'b1, 2, 32);
    add_item(21845, 1'b1, 1, 42);
    add_item(43690, 1'b1, 2, 21);
    add_item(7, 1'b1, 0, 1);
    add_item(12345, 1'b1, 2, 16);
    add_item(60000, 1'b1, 1, 8);
    for (int i = 0; i < NumRandom; i++) lcd_item_q.push_back(random_item());

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (lcd_item_q.size() != 0 || start) @(negedge clk_i);
    while (bus_write_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);

    if (bus_write_q.size() != 0)
      report_mismatch($sformatf("%0d writes never arrived", bus_write_q.size()));
    $display("run covered %0d numbers, %0d with a cursor move, %0d bus writes checked",
             items_taken, moves_taken, writes_checked);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
